### design/ske_pkg.sv
// Shared constants and types for the scalar Kalman estimator.
package ske_pkg;

   // Register file indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_ERR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_ERR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE = 2'd2;

   // Fixed field widths
   localparam int CFG_W = 16;
   localparam int IO_W  = 16;
   localparam int ERR_INT_W = 32;

   // Shared adder operation
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

### design/ske_alu.sv
// Shared adder/subtractor with carry out (carry high on subtract means no borrow).
module ske_alu import ske_pkg::*; #(
   parameter int WIDTH = 50
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  alu_op_type       op,
   output logic [WIDTH-1:0] res,
   output logic             carry
);

   logic [WIDTH:0] full;
   logic [WIDTH-1:0] b_eff;

   // Two's complement subtract by inverted operand and carry in
   assign b_eff = (op == ALU_SUB) ? ~b : b;
   assign full  = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (op == ALU_SUB)};
   assign res   = full[WIDTH-1:0];
   assign carry = full[WIDTH];

endmodule

### design/scalar_kalman_estimator_unit.sv
// Top level of the scalar Kalman estimator: sequencer around one shared adder.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | req_measurement[15:0]
//  rsp     | out       | rsp_valid/rsp_ready   | rsp_filtered_value[15:0]
//  csr     | in        | csr_valid/csr_ready   | csr_index[1:0], csr_data[15:0]
//
// Every step of a measurement goes through the one adder: restoring division
// for the gain, then three shift-add multiplies.
// A zero measurement_error skips the division.
// A finished result waits in an output register; the next transaction may be taken
// meanwhile and stalls before its commit until the output register is free.
// Synchronous reset clears sequencer and estimate, loads error and CSR defaults.
module scalar_kalman_estimator_unit import ske_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [IO_W-1:0]      req_measurement,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IO_W-1:0]      rsp_filtered_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int EST_W = SAMPLE_BITS + FRAC_BITS;
   localparam int ERR_W = ERR_INT_W + FRAC_BITS;
   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int BW = (GAIN_W > CFG_W) ? GAIN_W : CFG_W;
   localparam int PROD_W = ERR_W + BW;
   localparam int ADD_W = ERR_W + 2;
   localparam int CNT_W = $clog2(BW);
   localparam logic [GAIN_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ERR_W-1:0]  ERR_MAX = {ERR_W{1'b1}};

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEN   = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_DIFF2 = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_NEXT  = 4'd6;
   localparam logic [3:0] S_SUM   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // Multiply phases
   localparam logic [1:0] PH_STEP  = 2'd0;
   localparam logic [1:0] PH_KEEP  = 2'd1;
   localparam logic [1:0] PH_ADDED = 2'd2;

   // Control registers
   logic [3:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Filter state and configuration
   logic [EST_W-1:0] last_ff, last_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic [CFG_W-1:0] me_ff, me_in;
   logic [CFG_W-1:0] pn_ff, pn_in;

   // Working payload registers
   logic [EST_W-1:0]  meas_ff, meas_in;
   logic [ERR_W:0]    den_ff, den_in;
   logic [ERR_W:0]    rem_ff, rem_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              up_ff, up_in;
   logic [ERR_W-1:0]  mcand_ff, mcand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [EST_W-1:0]  step_ff, step_in;
   logic [ERR_W-1:0]  keep_ff, keep_in;
   logic [IO_W-1:0]   rsp_data_ff, rsp_data_in;

   // Shared adder
   logic [ADD_W-1:0] alu_a, alu_b, alu_res;
   alu_op_type       alu_op;
   logic             alu_carry;

   ske_alu #(.WIDTH(ADD_W)) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .op    (alu_op),
      .res   (alu_res),
      .carry (alu_carry)
   );

   // Helpers
   logic [IO_W+SAMPLE_BITS-1:0] meas_ext;
   logic [SAMPLE_BITS-1:0]      sample;
   logic [ERR_W-1:0]            prod_hi;
   logic [ERR_W:0]              prod_hi_new;
   logic [ERR_W-1:0]            added_sat;
   logic [EST_W+IO_W-1:0]       out_ext;
   logic                        cnt_last;
   logic                        req_fire, rsp_fire, csr_fire;

   assign meas_ext  = {{SAMPLE_BITS{1'b0}}, req_measurement};
   assign sample    = meas_ext[SAMPLE_BITS-1:0];
   assign prod_hi   = prod_ff[PROD_W-1:BW];
   assign added_sat = (prod_ff[PROD_W-1:ERR_W] != '0) ? ERR_MAX : prod_ff[ERR_W-1:0];
   assign out_ext   = {{IO_W{1'b0}}, last_ff};
   assign cnt_last  = (cnt_ff == CNT_W'(BW - 1));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_data_ff;

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      last_in      = last_ff;
      err_in       = err_ff;
      me_in        = me_ff;
      pn_in        = pn_ff;
      meas_in      = meas_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      up_in        = up_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      keep_in      = keep_ff;
      rsp_data_in  = rsp_data_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_op       = ALU_ADD;
      prod_hi_new  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               meas_in  = {sample, {FRAC_BITS{1'b0}}};
               state_in = S_DEN;
            end
         end
         // Gain denominator; zero measurement error resolves the gain directly
         S_DEN: begin
            alu_a   = ADD_W'(err_ff);
            alu_b   = ADD_W'({me_ff, {FRAC_BITS{1'b0}}});
            den_in  = alu_res[ERR_W:0];
            rem_in  = {1'b0, err_ff};
            cnt_in  = '0;
            gain_in = '0;
            if (me_ff == '0) begin
               gain_in  = (err_ff != '0) ? ONE_Q : '0;
               state_in = S_DIFF;
            end else begin
               state_in = S_DIV;
            end
         end
         // Restoring division, one quotient bit per cycle
         S_DIV: begin
            alu_a  = ADD_W'({rem_ff, 1'b0});
            alu_b  = ADD_W'(den_ff);
            alu_op = ALU_SUB;
            if (alu_carry) begin
               rem_in  = alu_res[ERR_W:0];
               gain_in = {gain_ff[GAIN_W-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[ERR_W-1:0], 1'b0};
               gain_in = {gain_ff[GAIN_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
               state_in = S_DIFF;
            end
         end
         // Magnitude of measurement minus estimate
         S_DIFF: begin
            alu_a  = ADD_W'(meas_ff);
            alu_b  = ADD_W'(last_ff);
            alu_op = ALU_SUB;
            up_in  = alu_carry;
            if (alu_carry) begin
               mcand_in = ERR_W'(alu_res[EST_W-1:0]);
               prod_in  = PROD_W'(gain_ff);
               phase_in = PH_STEP;
               cnt_in   = '0;
               state_in = S_MUL;
            end else begin
               state_in = S_DIFF2;
            end
         end
         S_DIFF2: begin
            alu_a    = ADD_W'(last_ff);
            alu_b    = ADD_W'(meas_ff);
            alu_op   = ALU_SUB;
            mcand_in = ERR_W'(alu_res[EST_W-1:0]);
            prod_in  = PROD_W'(gain_ff);
            phase_in = PH_STEP;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         // Shift-add multiply, LSB first
         S_MUL: begin
            alu_a       = ADD_W'(prod_hi);
            alu_b       = ADD_W'(mcand_ff);
            prod_hi_new = prod_ff[0] ? alu_res[ERR_W:0] : {1'b0, prod_hi};
            prod_in     = {prod_hi_new, prod_ff[BW-1:1]};
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in = '0;
               case (phase_ff)
                  PH_STEP: begin
                     step_in  = prod_in[FRAC_BITS +: EST_W];
                     state_in = S_NEXT;
                  end
                  PH_KEEP: begin
                     keep_in  = prod_in[FRAC_BITS +: ERR_W];
                     mcand_in = ERR_W'(step_ff);
                     prod_in  = PROD_W'(pn_ff);
                     phase_in = PH_ADDED;
                  end
                  default: begin
                     state_in = S_SUM;
                  end
               endcase
            end
         end
         // New estimate, then load err * (1 - gain)
         S_NEXT: begin
            alu_a    = ADD_W'(last_ff);
            alu_b    = ADD_W'(step_ff);
            alu_op   = up_ff ? ALU_ADD : ALU_SUB;
            last_in  = alu_res[EST_W-1:0];
            mcand_in = err_ff;
            prod_in  = PROD_W'(ONE_Q - gain_ff);
            phase_in = PH_KEEP;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         // Saturating error sum
         S_SUM: begin
            alu_a    = ADD_W'(keep_ff);
            alu_b    = ADD_W'(added_sat);
            err_in   = alu_res[ERR_W] ? ERR_MAX : alu_res[ERR_W-1:0];
            state_in = S_DONE;
         end
         // Hand result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = out_ext[FRAC_BITS +: IO_W];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes
      if (csr_fire) begin
         case (csr_index)
            CSR_MEAS_ERR: me_in = csr_data;
            CSR_INIT_ERR: begin
               err_in  = ERR_W'({csr_data, {FRAC_BITS{1'b0}}});
               last_in = '0;
            end
            CSR_PROC_NOISE: pn_in = csr_data;
            default: ;
         endcase
      end
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_STEP;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         err_ff       <= ERR_W'({CFG_W'(1), {FRAC_BITS{1'b0}}});
         me_ff        <= CFG_W'(1);
         pn_ff        <= CFG_W'(1);
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         err_ff       <= err_in;
         me_ff        <= me_in;
         pn_ff        <= pn_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      gain_ff     <= gain_in;
      up_ff       <= up_in;
      mcand_ff    <= mcand_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      keep_ff     <= keep_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Partial remainder stays below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("division remainder not below divisor");

   // Gain never exceeds one
   a_gain_le_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && phase_ff == PH_STEP) |-> (gain_ff <= ONE_Q))
      else $error("gain above one");

   // Estimate step no larger than the difference it scales
   a_step_le_diff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT) |-> (ERR_W'(step_ff) <= mcand_ff))
      else $error("estimate step exceeds difference");

   // Kept error never grows
   a_keep_le_err: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (keep_ff <= err_ff))
      else $error("kept error exceeds prior error");

   // An accepted transaction starts the sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_DEN))
      else $error("accepted transaction did not start");

endmodule

### dv/testbench.sv
// Self-checking testbench for the scalar Kalman estimator unit.
module testbench;
   import ske_pkg::*;

   localparam int          FRACTION_BITS = 16;
   localparam logic [63:0] UNITY_GAIN    = 64'h0000_0000_0001_0000;
   localparam logic [127:0] ERROR_CEILING = 128'h0000_FFFF_FFFF_FFFF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 200;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [IO_W-1:0]      req_measurement;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [IO_W-1:0]      rsp_filtered_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   // Predicted filter state and register copies
   logic [31:0]    est_value;
   logic [47:0]    est_error;
   logic [CFG_W-1:0] noise_meas;
   logic [CFG_W-1:0] noise_init;
   logic [CFG_W-1:0] noise_proc;

   logic [IO_W-1:0] expected_estimates[$];
   int  fail_count   = 0;
   bit  idle_on      = 1'b1;
   bit  hold_request = 1'b0;
   int  sig_level    = 32768;

   scalar_kalman_estimator_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_measurement    (req_measurement),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Power-on state of the predictor
   function automatic void reset_filter_model();
      noise_meas = 16'd1;
      noise_init = 16'd1;
      noise_proc = 16'd1;
      est_value  = 32'd0;
      est_error  = {16'd0, 16'd1, 16'd0};
   endfunction

   // Register write as seen by the predictor
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] value);
      case (idx)
         CSR_MEAS_ERR: begin
            noise_meas = value;
         end
         CSR_INIT_ERR: begin
            noise_init = value;
            est_error  = {16'd0, value, 16'd0};
            est_value  = 32'd0;
         end
         CSR_PROC_NOISE: begin
            noise_proc = value;
         end
         default: begin
         end
      endcase
   endfunction

   // One filter update; returns the integer part of the new estimate
   function automatic logic [IO_W-1:0] predict_estimate(input logic [IO_W-1:0] sample);
      logic [63:0]  meas_q;
      logic [63:0]  last_q;
      logic [63:0]  err;
      logic [63:0]  denom;
      logic [63:0]  gain;
      logic [63:0]  remainder;
      logic [63:0]  diff;
      logic [63:0]  step;
      logic [63:0]  next_q;
      logic [127:0] keep;
      logic [127:0] added;
      logic [127:0] total;
      logic         rising;
      int           i;
      meas_q = {32'd0, sample, 16'd0};
      last_q = {32'd0, est_value};
      err    = {16'd0, est_error};
      denom  = err + {32'd0, noise_meas, 16'd0};
      // gain = err / (err + measurement_error), truncated
      if (denom == 64'd0) begin
         gain = 64'd0;
      end else if (err >= denom) begin
         gain = UNITY_GAIN;
      end else begin
         remainder = err;
         gain      = 64'd0;
         for (i = 0; i < FRACTION_BITS; i++) begin
            remainder = remainder << 1;
            gain      = gain << 1;
            if (remainder >= denom) begin
               remainder = remainder - denom;
               gain      = gain | 64'd1;
            end
         end
      end
      // estimate moves toward the measurement by gain * |difference|
      rising = (meas_q >= last_q);
      diff   = rising ? meas_q - last_q : last_q - meas_q;
      step   = (diff * gain) >> FRACTION_BITS;
      if (step > diff) step = diff;
      next_q = rising ? last_q + step : last_q - step;
      // error update, every term saturating
      keep = ({64'd0, err} * {64'd0, UNITY_GAIN - gain}) >> FRACTION_BITS;
      if (keep > ERROR_CEILING) keep = ERROR_CEILING;
      added = {64'd0, step} * {112'd0, noise_proc};
      if (added > ERROR_CEILING) added = ERROR_CEILING;
      total = keep + added;
      if (total > ERROR_CEILING) total = ERROR_CEILING;
      est_error = total[47:0];
      est_value = next_q[31:0];
      return est_value[31:16];
   endfunction

   // Register setting: extremes often, otherwise random
   function automatic logic [CFG_W-1:0] pick_setting();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001;
         3: return 16'($urandom_range(0, 16));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Sensor-like samples: noisy level, level jumps, outliers, extremes
   function automatic logic [IO_W-1:0] random_measurement();
      int v;
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom_range(0, 65535));
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         3: begin
            sig_level = $urandom_range(0, 65535);
            return 16'(sig_level);
         end
         default: begin
            v = sig_level + $urandom_range(0, 512) - 256;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return 16'(v);
         end
      endcase
   endfunction

   // Send one measurement transaction and record its expected estimate
   task automatic send_measurement(input logic [IO_W-1:0] sample);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= sample;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_estimates.push_back(predict_estimate(sample));
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_estimates.size() != 0) @(posedge clock);
   endtask

   // Register write transaction; only issued while the block is idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_registers();
      if ($urandom_range(0, 1)) begin
         write_register(CSR_MEAS_ERR, pick_setting());
         if ($urandom_range(0, 1)) write_register(CSR_INIT_ERR, pick_setting());
         write_register(CSR_PROC_NOISE, pick_setting());
      end else begin
         write_register(CSR_PROC_NOISE, pick_setting());
         if ($urandom_range(0, 1)) write_register(CSR_INIT_ERR, pick_setting());
         write_register(CSR_MEAS_ERR, pick_setting());
      end
   endtask

   // Power-on settings: gain one half at the first step
   task automatic test_reset_defaults();
      send_measurement(16'hFFFF);
      send_measurement(16'h0000);
      send_measurement(16'h8000);
      send_measurement(16'h0001);
      send_measurement(16'hFFFF);
      release_request();
      wait_for_results();
   endtask

   // Both error terms zero: gain forced to zero, estimate stays put
   task automatic test_zero_denominator();
      write_register(CSR_MEAS_ERR, 16'h0000);
      write_register(CSR_INIT_ERR, 16'h0000);
      send_measurement(16'h9C40);
      send_measurement(16'hFFFF);
      release_request();
      wait_for_results();
   endtask

   // Zero measurement noise: estimate jumps to the sample; error becomes the process noise term
   task automatic test_unit_gain();
      write_register(CSR_INIT_ERR, 16'hFFFF);
      write_register(CSR_PROC_NOISE, 16'hFFFF);
      send_measurement(16'hFFFF);
      send_measurement(16'hFFFF);
      send_measurement(16'h0000);
      send_measurement(16'h5A5A);
      release_request();
      wait_for_results();
   endtask

   // Heavy measurement noise: tiny truncated gain
   task automatic test_heavy_noise();
      write_register(CSR_MEAS_ERR, 16'hFFFF);
      write_register(CSR_INIT_ERR, 16'h0001);
      write_register(CSR_PROC_NOISE, 16'h0000);
      send_measurement(16'hFFFF);
      send_measurement(16'hFFFF);
      send_measurement(16'h0000);
      release_request();
      wait_for_results();
   endtask

   // Write to an unmapped index must leave everything alone
   task automatic test_unknown_index();
      write_register(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      write_register(CSR_UNUSED, 16'hFFFF);
      send_measurement(16'h1234);
      send_measurement(16'hEDCB);
      release_request();
      wait_for_results();
   endtask

   // Random settings per phase with sensor-like stimulus
   task automatic test_random_settings();
      for (int phase = 0; phase < 18; phase++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         random_registers();
         for (int n = 0; n < 60; n++) send_measurement(random_measurement());
         release_request();
         wait_for_results();
      end
      idle_on = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering transactions
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int n = 0; n < 12; n++) send_measurement(random_measurement());
      release_request();
      wait_for_results();
   endtask

   // Final stretch at full rate on both sides
   task automatic test_full_rate();
      idle_on = 1'b0;
      random_registers();
      for (int n = 0; n < 250; n++) send_measurement(random_measurement());
      release_request();
      wait_for_results();
   endtask

   // Receiver ready: random stall bursts, plus the long hold-off on request
   initial begin
      int stall_len;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_len = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (stall_len - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each result transaction with the oldest expected estimate
   initial begin
      logic [IO_W-1:0] want;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_estimates.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: filtered_value=%0d", rsp_filtered_value);
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_filtered_value !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch filtered_value: expected %0d, actual %0d",
                              want, rsp_filtered_value);
               end
            end
         end
      end
   end

   // Watchdog: too long without any transaction on any channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_measurement = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      reset_filter_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_denominator();
      test_unit_gain();
      test_heavy_noise();
      test_unknown_index();
      test_random_settings();
      test_backpressure();
      test_full_rate();

      repeat (TAIL_CYCLES) @(posedge clock);
      fail_count += expected_estimates.size();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
design/ske_pkg.sv
design/ske_alu.sv
design/scalar_kalman_estimator_unit.sv
dv/testbench.sv
